// File: hw/rtl/tfvm_pkg.sv
// ----------------------------------------------------------------------------
// tfvm_pkg
// Shared widths, constants, types and helpers of the four-thruster mixer.
// ----------------------------------------------------------------------------
package tfvm_pkg;

    localparam int IN_W          = 16;
    localparam int T_W           = 18;
    localparam int TMAG_W        = 17;
    localparam int IMAG_W        = 16;
    localparam int NUM_T         = 4;
    localparam int Q_W           = 11;
    localparam int R_W           = Q_W + TMAG_W;
    localparam int PROD_W        = TMAG_W + IMAG_W;
    localparam int PM_W          = 10;
    localparam int N_W           = PROD_W + PM_W;
    localparam int OUT_W         = 12;
    localparam int QDEPTH        = 4;
    localparam int FRAC_BITS_DEF = 14;

    localparam logic [PM_W-1:0] PER_MILLE   = 10'd1000;
    localparam logic [Q_W-1:0]  DRIVE_LIMIT = 11'd2000;

    typedef logic [NUM_T-1:0][T_W-1:0]   t_thr_vec;
    typedef logic [NUM_T-1:0][OUT_W-1:0] t_drive_vec;

    typedef struct packed {
        t_thr_vec            thr;
        logic [IMAG_W-1:0]   max_in;
        logic [TMAG_W-1:0]   max_t;
        logic                oor;
        logic                zero;
    } t_mix_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic logic [TMAG_W-1:0] mag_t(input logic [T_W-1:0] v);
        logic [T_W-1:0] neg;
        neg = -v;
        return v[T_W-1] ? neg[TMAG_W-1:0] : v[TMAG_W-1:0];
    endfunction

endpackage

// File: hw/rtl/tfvm_front.sv
// ----------------------------------------------------------------------------
// tfvm_front
// Accepts commands, forms the four raw mixes, the input and thrust maxima and
// the range and all-zero flags, and pushes one item per transaction to the queue.
// ----------------------------------------------------------------------------
module tfvm_front #(
    parameter int FRAC_BITS = tfvm_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [tfvm_pkg::IN_W-1:0]    i_surge,
    input  logic signed [tfvm_pkg::IN_W-1:0]    i_sway,
    input  logic signed [tfvm_pkg::IN_W-1:0]    i_yaw,
    output logic                                o_busy,
    input  tfvm_pkg::t_q_stat                   i_q_stat,
    input  logic                                i_pop,
    output logic                                o_push,
    output tfvm_pkg::t_mix_item                 o_item
);
    import tfvm_pkg::*;

    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    logic                  r_s1_vld;
    t_thr_vec              r_s1_thr;
    logic [IMAG_W-1:0]     r_s1_imag [3];
    logic                  r_s1_oor;
    logic                  r_s2_vld;
    t_mix_item             r_s2_item;

    t_thr_vec              n_s1_thr;
    logic [IMAG_W-1:0]     n_s1_imag [3];
    logic                  n_s1_oor;
    t_mix_item             n_s2_item;

    logic                  s1_adv;
    logic                  s2_adv;
    logic                  accept;

    logic signed [T_W-1:0] xe;
    logic signed [T_W-1:0] ye;
    logic signed [T_W-1:0] re;
    logic signed [IMAG_W:0] ext [3];
    logic        [IMAG_W:0] negx [3];
    logic [TMAG_W-1:0]     tmag [NUM_T];
    logic [TMAG_W-1:0]     max_a;
    logic [TMAG_W-1:0]     max_b;
    logic [IMAG_W-1:0]     max_i;

    assign s2_adv = !r_s2_vld || !i_q_stat.full || i_pop;
    assign s1_adv = !r_s1_vld || s2_adv;
    assign o_busy = !s1_adv;
    assign accept = i_start && s1_adv;
    assign o_push = r_s2_vld && (!i_q_stat.full || i_pop);
    assign o_item = r_s2_item;

    always_comb begin
        xe = T_W'(i_surge);
        ye = T_W'(i_sway);
        re = T_W'(i_yaw);
        n_s1_thr[0] = xe - ye - re;
        n_s1_thr[1] = -xe - ye + re;
        n_s1_thr[2] = -xe + ye - re;
        n_s1_thr[3] = xe + ye + re;
        ext[0] = (IMAG_W+1)'(i_surge);
        ext[1] = (IMAG_W+1)'(i_sway);
        ext[2] = (IMAG_W+1)'(i_yaw);
        n_s1_oor = 1'b0;
        for (int k = 0; k < 3; k++) begin
            negx[k] = -ext[k];
            n_s1_imag[k] = ext[k][IMAG_W] ? negx[k][IMAG_W-1:0] : ext[k][IMAG_W-1:0];
            n_s1_oor = n_s1_oor || (32'(n_s1_imag[k]) > ONE);
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_T; k++) begin
            tmag[k] = mag_t(r_s1_thr[k]);
        end
        max_a = (tmag[0] > tmag[1]) ? tmag[0] : tmag[1];
        max_b = (tmag[2] > tmag[3]) ? tmag[2] : tmag[3];
        max_i = (r_s1_imag[0] > r_s1_imag[1]) ? r_s1_imag[0] : r_s1_imag[1];
        n_s2_item.thr    = r_s1_thr;
        n_s2_item.max_t  = (max_a > max_b) ? max_a : max_b;
        n_s2_item.max_in = (max_i > r_s1_imag[2]) ? max_i : r_s1_imag[2];
        n_s2_item.oor    = r_s1_oor;
        n_s2_item.zero   = (n_s2_item.max_t == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_vld <= accept;
            end
            if (s2_adv) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_thr  <= n_s1_thr;
            r_s1_imag <= n_s1_imag;
            r_s1_oor  <= n_s1_oor;
        end
        if (s2_adv && r_s1_vld) begin
            r_s2_item <= n_s2_item;
        end
    end

endmodule

// File: hw/rtl/tfvm_queue.sv
// ----------------------------------------------------------------------------
// tfvm_queue
// Short first-in first-out queue of mixed items between front and back.
// ----------------------------------------------------------------------------
module tfvm_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tfvm_pkg::t_mix_item i_item,
    input  logic                i_pop,
    output tfvm_pkg::t_q_stat   o_stat,
    output tfvm_pkg::t_mix_item o_item
);
    import tfvm_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_mix_item          r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(QDEPTH));
    assign o_item       = r_mem[r_rd_ptr];
    assign n_count      = r_count + CNT_W'(i_push) - CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full && !i_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("queue pop while empty");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count did not advance on push");

endmodule

// File: hw/rtl/tfvm_back.sv
// ----------------------------------------------------------------------------
// tfvm_back
// Scales the four mixes: product with the input maximum and per-mille factor,
// fraction shift, then a restoring divide by the thrust maximum, one quotient
// bit per stage, with saturation, sign and all-zero handling.
// ----------------------------------------------------------------------------
module tfvm_back #(
    parameter int FRAC_BITS = tfvm_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  tfvm_pkg::t_mix_item  i_item,
    output logic                 o_strobe,
    output tfvm_pkg::t_drive_vec o_drive,
    output logic                 o_oor
);
    import tfvm_pkg::*;

    localparam int LAT = Q_W + 4;

    logic                r_b1_vld;
    logic [PROD_W-1:0]   r_b1_prod [NUM_T];
    logic [NUM_T-1:0]    r_b1_neg;
    logic [TMAG_W-1:0]   r_b1_maxt;
    logic                r_b1_zero;
    logic                r_b1_oor;

    logic                r_b2_vld;
    logic [N_W-1:0]      r_b2_n [NUM_T];
    logic [NUM_T-1:0]    r_b2_neg;
    logic [TMAG_W-1:0]   r_b2_maxt;
    logic                r_b2_zero;
    logic                r_b2_oor;

    logic                r_dv_vld  [Q_W+1];
    logic [R_W-1:0]      r_dv_rem  [Q_W+1][NUM_T];
    logic [Q_W-1:0]      r_dv_q    [Q_W+1][NUM_T];
    logic [NUM_T-1:0]    r_dv_sat  [Q_W+1];
    logic [NUM_T-1:0]    r_dv_neg  [Q_W+1];
    logic [TMAG_W-1:0]   r_dv_maxt [Q_W+1];
    logic                r_dv_zero [Q_W+1];
    logic                r_dv_oor  [Q_W+1];

    logic                r_out_vld;
    t_drive_vec          r_out_drive;
    logic                r_out_oor;

    logic [PROD_W-1:0]   n_b1_prod [NUM_T];
    logic [NUM_T-1:0]    n_b1_neg;
    logic [R_W-1:0]      n_dv_rem0 [NUM_T];
    logic [NUM_T-1:0]    n_dv_sat0;
    logic [R_W-1:0]      n_dv_rem  [Q_W+1][NUM_T];
    logic [Q_W-1:0]      n_dv_q    [Q_W+1][NUM_T];
    t_drive_vec          n_out_drive;

    logic [N_W-1:0]      shifted [NUM_T];
    logic [R_W-1:0]      dvsr;
    logic [Q_W-1:0]      qsat;
    logic [OUT_W-1:0]    qext;

    always_comb begin
        for (int i = 0; i < NUM_T; i++) begin
            n_b1_prod[i] = PROD_W'(mag_t(i_item.thr[i])) * PROD_W'(i_item.max_in);
            n_b1_neg[i]  = i_item.thr[i][T_W-1];
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_T; i++) begin
            shifted[i]   = r_b2_n[i] >> FRAC_BITS;
            n_dv_sat0[i] = (shifted[i] >> Q_W) >= N_W'(r_b2_maxt);
            n_dv_rem0[i] = shifted[i][R_W-1:0];
        end
    end

    always_comb begin
        dvsr = '0;
        for (int k = 0; k <= Q_W; k++) begin
            for (int i = 0; i < NUM_T; i++) begin
                n_dv_rem[k][i] = '0;
                n_dv_q[k][i]   = '0;
            end
        end
        for (int k = 1; k <= Q_W; k++) begin
            dvsr = R_W'(r_dv_maxt[k-1]) << (Q_W - k);
            for (int i = 0; i < NUM_T; i++) begin
                if (r_dv_rem[k-1][i] >= dvsr) begin
                    n_dv_rem[k][i] = r_dv_rem[k-1][i] - dvsr;
                    n_dv_q[k][i]   = r_dv_q[k-1][i] | (Q_W'(1) << (Q_W - k));
                end else begin
                    n_dv_rem[k][i] = r_dv_rem[k-1][i];
                    n_dv_q[k][i]   = r_dv_q[k-1][i];
                end
            end
        end
    end

    always_comb begin
        qsat = '0;
        qext = '0;
        for (int i = 0; i < NUM_T; i++) begin
            if (r_dv_zero[Q_W]) begin
                qsat = '0;
            end else if (r_dv_sat[Q_W][i] || (r_dv_q[Q_W][i] > DRIVE_LIMIT)) begin
                qsat = DRIVE_LIMIT;
            end else begin
                qsat = r_dv_q[Q_W][i];
            end
            qext = OUT_W'(qsat);
            n_out_drive[i] = r_dv_neg[Q_W][i] ? -qext : qext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld  <= 1'b0;
            r_b2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= Q_W; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else begin
            r_b1_vld    <= i_vld;
            r_b2_vld    <= r_b1_vld;
            r_dv_vld[0] <= r_b2_vld;
            for (int k = 1; k <= Q_W; k++) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
            r_out_vld <= r_dv_vld[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_prod <= n_b1_prod;
        r_b1_neg  <= n_b1_neg;
        r_b1_maxt <= i_item.max_t;
        r_b1_zero <= i_item.zero;
        r_b1_oor  <= i_item.oor;

        for (int i = 0; i < NUM_T; i++) begin
            r_b2_n[i] <= N_W'(r_b1_prod[i]) * N_W'(PER_MILLE);
        end
        r_b2_neg  <= r_b1_neg;
        r_b2_maxt <= r_b1_maxt;
        r_b2_zero <= r_b1_zero;
        r_b2_oor  <= r_b1_oor;

        for (int i = 0; i < NUM_T; i++) begin
            r_dv_rem[0][i] <= n_dv_rem0[i];
            r_dv_q[0][i]   <= '0;
        end
        r_dv_sat[0]  <= n_dv_sat0;
        r_dv_neg[0]  <= r_b2_neg;
        r_dv_maxt[0] <= r_b2_maxt;
        r_dv_zero[0] <= r_b2_zero;
        r_dv_oor[0]  <= r_b2_oor;

        for (int k = 1; k <= Q_W; k++) begin
            for (int i = 0; i < NUM_T; i++) begin
                r_dv_rem[k][i] <= n_dv_rem[k][i];
                r_dv_q[k][i]   <= n_dv_q[k][i];
            end
            r_dv_sat[k]  <= r_dv_sat[k-1];
            r_dv_neg[k]  <= r_dv_neg[k-1];
            r_dv_maxt[k] <= r_dv_maxt[k-1];
            r_dv_zero[k] <= r_dv_zero[k-1];
            r_dv_oor[k]  <= r_dv_oor[k-1];
        end

        r_out_drive <= n_out_drive;
        r_out_oor   <= r_dv_oor[Q_W];
    end

    assign o_strobe = r_out_vld;
    assign o_drive  = r_out_drive;
    assign o_oor    = r_out_oor;

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld |-> ##LAT o_strobe)
        else $error("result strobe missing after fixed latency");

    a_zero_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && i_item.zero) |-> ##LAT (o_drive == '0))
        else $error("all-zero command gave non-zero drive");

endmodule

// File: hw/rtl/four_thruster_vector_mixer.sv
// ----------------------------------------------------------------------------
// four_thruster_vector_mixer
// Mixes surge, sway and yaw into four per-mille thruster drives.
// ----------------------------------------------------------------------------
// A command is taken on a rising edge with start high and busy low; one
// command may follow every cycle. Its result appears on the o_thrust_* and
// o_out_of_range ports for exactly one cycle with o_strobe high, 18 cycles
// after the cycle in which the command was taken, and must be captured then:
// there is no way to hold results off. Results leave in command order. The
// latency is set by the two front stages, the queue slot, two multiply stages,
// the fraction shift stage, eleven restoring divide stages (one quotient bit
// each, four lanes) and the output register. The back end drains the queue
// every cycle, so busy stays low in normal use.
// ----------------------------------------------------------------------------
module four_thruster_vector_mixer #(
    parameter int FRAC_BITS = tfvm_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [tfvm_pkg::IN_W-1:0]     i_surge,
    input  logic signed [tfvm_pkg::IN_W-1:0]     i_sway,
    input  logic signed [tfvm_pkg::IN_W-1:0]     i_yaw,
    output logic                                 o_strobe,
    output logic signed [tfvm_pkg::OUT_W-1:0]    o_thrust_one,
    output logic signed [tfvm_pkg::OUT_W-1:0]    o_thrust_two,
    output logic signed [tfvm_pkg::OUT_W-1:0]    o_thrust_three,
    output logic signed [tfvm_pkg::OUT_W-1:0]    o_thrust_four,
    output logic                                 o_out_of_range
);
    import tfvm_pkg::*;

    t_q_stat     q_stat;
    t_mix_item   push_item;
    t_mix_item   head_item;
    logic        push;
    logic        pop;
    t_drive_vec  drive;

    assign pop = !q_stat.empty;

    tfvm_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_surge  (i_surge),
        .i_sway   (i_sway),
        .i_yaw    (i_yaw),
        .o_busy   (busy),
        .i_q_stat (q_stat),
        .i_pop    (pop),
        .o_push   (push),
        .o_item   (push_item)
    );

    tfvm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_item  (head_item)
    );

    tfvm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (pop),
        .i_item   (head_item),
        .o_strobe (o_strobe),
        .o_drive  (drive),
        .o_oor    (o_out_of_range)
    );

    assign o_thrust_one   = drive[0];
    assign o_thrust_two   = drive[1];
    assign o_thrust_three = drive[2];
    assign o_thrust_four  = drive[3];

endmodule
